FILE: rtl/ledfp_pkg.sv
// ----------------------------------------------------------------------------
// ledfp_pkg
// Types and constants of the LED driver fault protection unit: item layouts,
// fault log bit positions, current-limit codes and configuration indexes.
// ----------------------------------------------------------------------------
package ledfp_pkg;

    localparam int VIN_W   = 16;
    localparam int TEMP_W  = 13;
    localparam int FAULT_W = 6;
    localparam int LEVEL_W = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 16;

    // Bit positions in the fault log.
    localparam int F_OCP_WARM  = 0;
    localparam int F_OCP_COOL  = 1;
    localparam int F_TEMP_SD   = 2;
    localparam int F_TEMP_WARN = 3;
    localparam int F_UV        = 4;
    localparam int F_OV        = 5;

    typedef enum logic [LEVEL_W-1:0] {
        LEVEL_FULL   = 2'd0,
        LEVEL_DERATE = 2'd1,
        LEVEL_ZERO   = 2'd2
    } level_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_SHUTDOWN     = 3'd0,
        CFG_TEMP_WARN         = 3'd1,
        CFG_TEMP_WARN_CLEAR   = 3'd2,
        CFG_VIN_UNDER         = 3'd3,
        CFG_VIN_OVER          = 3'd4,
        CFG_VIN_UNDER_RECOVER = 3'd5,
        CFG_VIN_OVER_RECOVER  = 3'd6
    } cfg_index_t;

    localparam logic [TEMP_W-1:0] RST_TEMP_SHUTDOWN     = 13'd1760;
    localparam logic [TEMP_W-1:0] RST_TEMP_WARN         = 13'd1440;
    localparam logic [TEMP_W-1:0] RST_TEMP_WARN_CLEAR   = 13'd1280;
    localparam logic [VIN_W-1:0]  RST_VIN_UNDER         = 16'd40000;
    localparam logic [VIN_W-1:0]  RST_VIN_OVER          = 16'd56000;
    localparam logic [VIN_W-1:0]  RST_VIN_UNDER_RECOVER = 16'd42000;
    localparam logic [VIN_W-1:0]  RST_VIN_OVER_RECOVER  = 16'd54000;

    // Input sample as packed in s_tdata, lowest field last.
    typedef struct packed {
        logic              pad;
        logic              ocp_cool;
        logic              ocp_warm;
        logic [TEMP_W-1:0] temp_q4;
        logic [VIN_W-1:0]  vin_mv;
    } sample_t;

    // Result as packed in m_tdata, lowest field last.
    typedef struct packed {
        logic [2:0]         pad;
        logic               ballast_failure;
        logic               lamp_failure;
        logic [FAULT_W-1:0] fault_flags;
        logic               cool_on;
        logic               warm_on;
        logic               buck_on;
        level_t             limit_level;
    } result_t;

endpackage

FILE: rtl/led_driver_fault_protection_unit.sv
// ----------------------------------------------------------------------------
// led_driver_fault_protection_unit
// Per-sample fault protection for a two-channel LED driver: channel, buck and
// current-limit control with sticky fault and failure status.
// ----------------------------------------------------------------------------
// The unit takes one monitor sample per clock and returns one result per
// sample: the sample is registered, evaluated against the thresholds and the
// fault state in one pass of compare logic, and the result is held in an
// output register. The fault state is updated as the sample moves into the
// output register, so a new sample may follow in every cycle; the input side
// stalls only while the output register holds a result that has not been
// taken. Thresholds are written through the cfg port, which is always ready
// and should only be written while no sample is in flight.
module led_driver_fault_protection_unit #(
    parameter int RETRY_LIMIT = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Monitor samples.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // vin_mv[15:0], temp_q4[28:16], ocp_warm[29], ocp_cool[30]
    // Results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // limit_level[1:0], buck_on[2], warm_on[3], cool_on[4],
                                   // fault_flags[10:5], lamp_failure[11], ballast_failure[12]
    // Threshold writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int RETRY_W = $clog2(RETRY_LIMIT + 1);
    localparam logic [RETRY_W-1:0] RETRY_MAX = RETRY_W'(RETRY_LIMIT);

    // Thresholds.
    logic [ledfp_pkg::TEMP_W-1:0] temp_shutdown_reg;
    logic [ledfp_pkg::TEMP_W-1:0] temp_warn_reg;
    logic [ledfp_pkg::TEMP_W-1:0] temp_warn_clear_reg;
    logic [ledfp_pkg::VIN_W-1:0]  vin_under_reg;
    logic [ledfp_pkg::VIN_W-1:0]  vin_over_reg;
    logic [ledfp_pkg::VIN_W-1:0]  vin_under_recover_reg;
    logic [ledfp_pkg::VIN_W-1:0]  vin_over_recover_reg;

    // Fault state.
    logic [ledfp_pkg::FAULT_W-1:0] fault_status_reg, fault_status_next;
    logic [RETRY_W-1:0]            retry_warm_reg, retry_warm_next;
    logic [RETRY_W-1:0]            retry_cool_reg, retry_cool_next;
    logic                          lamp_fail_reg, lamp_fail_next;
    logic                          ballast_fail_reg, ballast_fail_next;

    // Pipeline.
    ledfp_pkg::sample_t sample_reg;
    logic               sample_valid_reg;
    ledfp_pkg::result_t result_reg, result_next;
    logic               result_valid_reg;
    logic               advance;

    logic signed [ledfp_pkg::TEMP_W-1:0] temp_s;

    assign advance   = !result_valid_reg || m_tready;
    assign s_tready  = !sample_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = result_valid_reg;
    assign m_tdata   = result_reg;
    assign temp_s    = $signed(sample_reg.temp_q4);

    always_comb begin
        fault_status_next = fault_status_reg;
        retry_warm_next   = retry_warm_reg;
        retry_cool_next   = retry_cool_reg;
        lamp_fail_next    = lamp_fail_reg;
        ballast_fail_next = ballast_fail_reg;
        result_next       = '0;
        result_next.limit_level = ledfp_pkg::LEVEL_FULL;
        result_next.buck_on     = 1'b1;
        result_next.warm_on     = 1'b1;
        result_next.cool_on     = 1'b1;

        if (sample_reg.ocp_warm) begin
            fault_status_next[ledfp_pkg::F_OCP_WARM] = 1'b1;
            lamp_fail_next      = 1'b1;
            result_next.warm_on = 1'b0;
            if (retry_warm_reg < RETRY_MAX) begin
                retry_warm_next = retry_warm_reg + 1'b1;
            end else begin
                result_next.buck_on = 1'b0;
            end
        end
        if (sample_reg.ocp_cool) begin
            fault_status_next[ledfp_pkg::F_OCP_COOL] = 1'b1;
            lamp_fail_next      = 1'b1;
            result_next.cool_on = 1'b0;
            if (retry_cool_reg < RETRY_MAX) begin
                retry_cool_next = retry_cool_reg + 1'b1;
            end else begin
                result_next.buck_on = 1'b0;
            end
        end

        if (temp_s >= $signed(temp_shutdown_reg)) begin
            fault_status_next[ledfp_pkg::F_TEMP_SD] = 1'b1;
            result_next.limit_level = ledfp_pkg::LEVEL_ZERO;
            result_next.buck_on     = 1'b0;
            result_next.warm_on     = 1'b0;
            result_next.cool_on     = 1'b0;
            ballast_fail_next       = 1'b1;
        end else if (temp_s >= $signed(temp_warn_reg)) begin
            fault_status_next[ledfp_pkg::F_TEMP_WARN] = 1'b1;
            result_next.limit_level = ledfp_pkg::LEVEL_DERATE;
        end else if (temp_s < $signed(temp_warn_clear_reg)) begin
            fault_status_next[ledfp_pkg::F_TEMP_WARN] = 1'b0;
        end

        if (sample_reg.vin_mv < vin_under_reg) begin
            fault_status_next[ledfp_pkg::F_UV] = 1'b1;
            result_next.buck_on = 1'b0;
            result_next.warm_on = 1'b0;
            result_next.cool_on = 1'b0;
        end else if (sample_reg.vin_mv > vin_over_reg) begin
            fault_status_next[ledfp_pkg::F_OV] = 1'b1;
            result_next.buck_on = 1'b0;
            result_next.warm_on = 1'b0;
            result_next.cool_on = 1'b0;
        end else begin
            // Both voltage flags recover only on a sample that is inside the window.
            if (sample_reg.vin_mv > vin_under_recover_reg) begin
                fault_status_next[ledfp_pkg::F_UV] = 1'b0;
            end
            if (sample_reg.vin_mv < vin_over_recover_reg) begin
                fault_status_next[ledfp_pkg::F_OV] = 1'b0;
            end
        end

        result_next.fault_flags     = fault_status_next;
        result_next.lamp_failure    = lamp_fail_next;
        result_next.ballast_failure = ballast_fail_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_shutdown_reg     <= ledfp_pkg::RST_TEMP_SHUTDOWN;
            temp_warn_reg         <= ledfp_pkg::RST_TEMP_WARN;
            temp_warn_clear_reg   <= ledfp_pkg::RST_TEMP_WARN_CLEAR;
            vin_under_reg         <= ledfp_pkg::RST_VIN_UNDER;
            vin_over_reg          <= ledfp_pkg::RST_VIN_OVER;
            vin_under_recover_reg <= ledfp_pkg::RST_VIN_UNDER_RECOVER;
            vin_over_recover_reg  <= ledfp_pkg::RST_VIN_OVER_RECOVER;
        end else if (cfg_valid && cfg_ready) begin
            case (ledfp_pkg::cfg_index_t'(cfg_index))
                ledfp_pkg::CFG_TEMP_SHUTDOWN: begin
                    temp_shutdown_reg <= cfg_data[ledfp_pkg::TEMP_W-1:0];
                end
                ledfp_pkg::CFG_TEMP_WARN: begin
                    temp_warn_reg <= cfg_data[ledfp_pkg::TEMP_W-1:0];
                end
                ledfp_pkg::CFG_TEMP_WARN_CLEAR: begin
                    temp_warn_clear_reg <= cfg_data[ledfp_pkg::TEMP_W-1:0];
                end
                ledfp_pkg::CFG_VIN_UNDER: begin
                    vin_under_reg <= cfg_data;
                end
                ledfp_pkg::CFG_VIN_OVER: begin
                    vin_over_reg <= cfg_data;
                end
                ledfp_pkg::CFG_VIN_UNDER_RECOVER: begin
                    vin_under_recover_reg <= cfg_data;
                end
                ledfp_pkg::CFG_VIN_OVER_RECOVER: begin
                    vin_over_recover_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
            fault_status_reg <= '0;
            retry_warm_reg   <= '0;
            retry_cool_reg   <= '0;
            lamp_fail_reg    <= 1'b0;
            ballast_fail_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                sample_valid_reg <= 1'b1;
            end else if (advance) begin
                sample_valid_reg <= 1'b0;
            end
            if (advance) begin
                result_valid_reg <= sample_valid_reg;
                if (sample_valid_reg) begin
                    fault_status_reg <= fault_status_next;
                    retry_warm_reg   <= retry_warm_next;
                    retry_cool_reg   <= retry_cool_next;
                    lamp_fail_reg    <= lamp_fail_next;
                    ballast_fail_reg <= ballast_fail_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            sample_reg <= s_tdata;
        end
        if (advance && sample_valid_reg) begin
            result_reg <= result_next;
        end
    end

`ifndef SYNTHESIS
    // The failure bits are only cleared by reset.
    a_lamp_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        lamp_fail_reg |=> lamp_fail_reg)
        else $error("lamp failure bit cleared without reset");

    a_ballast_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ballast_fail_reg |=> ballast_fail_reg)
        else $error("ballast failure bit cleared without reset");

    a_retry_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (retry_warm_reg <= RETRY_MAX) && (retry_cool_reg <= RETRY_MAX))
        else $error("retry counter above its limit");

    // A zero current limit comes only from a temperature shutdown.
    a_zero_level_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (result_reg.limit_level == ledfp_pkg::LEVEL_ZERO)) |->
        (!result_reg.buck_on && result_reg.fault_flags[ledfp_pkg::F_TEMP_SD]
         && result_reg.ballast_failure))
        else $error("zero current limit without shutdown");

    a_no_stall_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output side is ready");
`endif

endmodule

FILE: sim/led_driver_fault_protection_unit_tb.sv
// ----------------------------------------------------------------------------
// led_driver_fault_protection_unit_tb
// Self-checking testbench for the LED driver fault protection unit. Monitor
// samples go in on the s_ stream and status results come out on the m_
// stream. A scoreboard predicts each result from the accepted sample and its
// own copies of the thresholds and the fault state. Directed samples run at
// the reset thresholds; the phases rewrite them to both extremes, random and
// realistic bands. Each side idles at random except in one quiet phase.
// ----------------------------------------------------------------------------
module led_driver_fault_protection_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RETRY_LIMIT = 3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 200;
    localparam int IDLE_PCT    = 16;
    localparam logic [ledfp_pkg::CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

    class protection_scoreboard;
        logic signed [ledfp_pkg::TEMP_W-1:0] temp_sd, temp_warn, temp_clr;
        logic [ledfp_pkg::VIN_W-1:0]         vin_uv, vin_ov, vin_uv_rec, vin_ov_rec;
        logic [ledfp_pkg::FAULT_W-1:0]       fault_status;
        int unsigned                         retry_warm, retry_cool;
        logic                                lamp_fail, ballast_fail;
        ledfp_pkg::result_t                  pending_status[$];
        int unsigned                         errors;
        int unsigned                         results_seen;

        function new();
            temp_sd      = ledfp_pkg::RST_TEMP_SHUTDOWN;
            temp_warn    = ledfp_pkg::RST_TEMP_WARN;
            temp_clr     = ledfp_pkg::RST_TEMP_WARN_CLEAR;
            vin_uv       = ledfp_pkg::RST_VIN_UNDER;
            vin_ov       = ledfp_pkg::RST_VIN_OVER;
            vin_uv_rec   = ledfp_pkg::RST_VIN_UNDER_RECOVER;
            vin_ov_rec   = ledfp_pkg::RST_VIN_OVER_RECOVER;
            fault_status = '0;
            retry_warm   = 0;
            retry_cool   = 0;
            lamp_fail    = 1'b0;
            ballast_fail = 1'b0;
            errors       = 0;
            results_seen = 0;
        endfunction

        // Temperature registers keep only their low 13 bits.
        function void write_reg(logic [ledfp_pkg::CFG_IDX_W-1:0] idx,
                                logic [ledfp_pkg::CFG_DATA_W-1:0] data);
            case (ledfp_pkg::cfg_index_t'(idx))
                ledfp_pkg::CFG_TEMP_SHUTDOWN:     temp_sd    = data[ledfp_pkg::TEMP_W-1:0];
                ledfp_pkg::CFG_TEMP_WARN:         temp_warn  = data[ledfp_pkg::TEMP_W-1:0];
                ledfp_pkg::CFG_TEMP_WARN_CLEAR:   temp_clr   = data[ledfp_pkg::TEMP_W-1:0];
                ledfp_pkg::CFG_VIN_UNDER:         vin_uv     = data;
                ledfp_pkg::CFG_VIN_OVER:          vin_ov     = data;
                ledfp_pkg::CFG_VIN_UNDER_RECOVER: vin_uv_rec = data;
                ledfp_pkg::CFG_VIN_OVER_RECOVER:  vin_ov_rec = data;
                default: ;
            endcase
        endfunction

        function ledfp_pkg::result_t protect_step(ledfp_pkg::sample_t s);
            ledfp_pkg::result_t                  r;
            logic signed [ledfp_pkg::TEMP_W-1:0] t;
            logic                                buck, warm, cool;
            ledfp_pkg::level_t                   lvl;
            t    = s.temp_q4;
            buck = 1'b1;
            warm = 1'b1;
            cool = 1'b1;
            lvl  = ledfp_pkg::LEVEL_FULL;
            if (s.ocp_warm) begin
                fault_status[ledfp_pkg::F_OCP_WARM] = 1'b1;
                lamp_fail = 1'b1;
                warm = 1'b0;
                if (retry_warm < RETRY_LIMIT) retry_warm++;
                else buck = 1'b0;
            end
            if (s.ocp_cool) begin
                fault_status[ledfp_pkg::F_OCP_COOL] = 1'b1;
                lamp_fail = 1'b1;
                cool = 1'b0;
                if (retry_cool < RETRY_LIMIT) retry_cool++;
                else buck = 1'b0;
            end
            if (t >= temp_sd) begin
                fault_status[ledfp_pkg::F_TEMP_SD] = 1'b1;
                lvl = ledfp_pkg::LEVEL_ZERO;
                buck = 1'b0;
                warm = 1'b0;
                cool = 1'b0;
                ballast_fail = 1'b1;
            end else if (t >= temp_warn) begin
                fault_status[ledfp_pkg::F_TEMP_WARN] = 1'b1;
                lvl = ledfp_pkg::LEVEL_DERATE;
            end else if (t < temp_clr) begin
                fault_status[ledfp_pkg::F_TEMP_WARN] = 1'b0;
            end
            // The voltage flags only recover on a sample that shows neither fault.
            if (s.vin_mv < vin_uv) begin
                fault_status[ledfp_pkg::F_UV] = 1'b1;
                buck = 1'b0;
                warm = 1'b0;
                cool = 1'b0;
            end else if (s.vin_mv > vin_ov) begin
                fault_status[ledfp_pkg::F_OV] = 1'b1;
                buck = 1'b0;
                warm = 1'b0;
                cool = 1'b0;
            end else begin
                if (s.vin_mv > vin_uv_rec) fault_status[ledfp_pkg::F_UV] = 1'b0;
                if (s.vin_mv < vin_ov_rec) fault_status[ledfp_pkg::F_OV] = 1'b0;
            end
            r                 = '0;
            r.limit_level     = lvl;
            r.buck_on         = buck;
            r.warm_on         = warm;
            r.cool_on         = cool;
            r.fault_flags     = fault_status;
            r.lamp_failure    = lamp_fail;
            r.ballast_failure = ballast_fail;
            return r;
        endfunction

        function void note_sample(ledfp_pkg::sample_t s);
            pending_status.push_back(protect_step(s));
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] status mismatch: %s", $realtime, msg);
        endtask

        task check_field(string name, int unsigned exp_val, int unsigned got_val);
            if (got_val !== exp_val)
                report($sformatf("result %0d %s expected %0d got %0d",
                                 results_seen, name, exp_val, got_val));
        endtask

        task check_result(ledfp_pkg::result_t got);
            ledfp_pkg::result_t want;
            if (pending_status.size() == 0) begin
                report($sformatf("result %0d arrived with no sample waiting", results_seen));
            end else begin
                want = pending_status.pop_front();
                check_field("limit_level", want.limit_level, got.limit_level);
                check_field("buck_on", want.buck_on, got.buck_on);
                check_field("warm_on", want.warm_on, got.warm_on);
                check_field("cool_on", want.cool_on, got.cool_on);
                check_field("fault_flags", want.fault_flags, got.fault_flags);
                check_field("lamp_failure", want.lamp_failure, got.lamp_failure);
                check_field("ballast_failure", want.ballast_failure, got.ballast_failure);
            end
            results_seen++;
        endtask
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;   // vin_mv, temp_q4, ocp_warm, ocp_cool
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;          // limit_level, buck_on, warm_on, cool_on,
                                   // fault_flags, lamp_failure, ballast_failure
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    bit          no_idle   = 1'b0;
    int unsigned cycles    = 0;

    protection_scoreboard sb = new();

    led_driver_fault_protection_unit #(
        .RETRY_LIMIT(RETRY_LIMIT)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("led_driver_fault_protection_unit regression: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_sample(s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
        end
    end

    always @(negedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic ledfp_pkg::sample_t mk_sample(int vin, int temp, bit ow, bit oc);
        ledfp_pkg::sample_t s;
        s          = '0;
        s.vin_mv   = vin[ledfp_pkg::VIN_W-1:0];
        s.temp_q4  = temp[ledfp_pkg::TEMP_W-1:0];
        s.ocp_warm = ow;
        s.ocp_cool = oc;
        return s;
    endfunction

    // Four in ten samples sit close to a threshold so that the hysteresis bands are
    // crossed often; the rest lie in a normal band or spread over the whole field.
    function automatic ledfp_pkg::sample_t random_sample();
        int vin, temp, off;
        int unsigned pick;
        off  = int'($urandom_range(6)) - 3;
        pick = $urandom_range(9);
        if (pick < 2) begin
            vin = $urandom_range(65535);
        end else if (pick < 6) begin
            case ($urandom_range(3))
                0:       vin = sb.vin_uv;
                1:       vin = sb.vin_ov;
                2:       vin = sb.vin_uv_rec;
                default: vin = sb.vin_ov_rec;
            endcase
            vin = vin + off;
        end else begin
            vin = $urandom_range(53500, 42500);
        end
        off  = int'($urandom_range(6)) - 3;
        pick = $urandom_range(9);
        if (pick < 2) begin
            temp = $urandom_range(8191);
        end else if (pick < 6) begin
            case ($urandom_range(2))
                0:       temp = sb.temp_sd;
                1:       temp = sb.temp_warn;
                default: temp = sb.temp_clr;
            endcase
            temp = temp + off;
        end else begin
            temp = $urandom_range(1200);
        end
        return mk_sample(vin, temp, $urandom_range(99) < 10, $urandom_range(99) < 10);
    endfunction

    task send_sample(input ledfp_pkg::sample_t s);
        @(negedge aclk);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= s;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Ends a burst and waits until every status has come back, so that the
    // thresholds can be changed with nothing in flight.
    task drain();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (sb.pending_status.size() != 0) @(posedge aclk);
    endtask

    task write_cfg(input logic [ledfp_pkg::CFG_IDX_W-1:0] idx,
                   input logic [ledfp_pkg::CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk) cfg_valid <= 1'b0;
    endtask

    task write_thresholds(input int ts, input int tw, input int tc, input int vu,
                          input int vo, input int vur, input int vor);
        write_cfg(ledfp_pkg::CFG_TEMP_SHUTDOWN, ts[15:0]);
        write_cfg(ledfp_pkg::CFG_TEMP_WARN, tw[15:0]);
        write_cfg(ledfp_pkg::CFG_TEMP_WARN_CLEAR, tc[15:0]);
        write_cfg(ledfp_pkg::CFG_VIN_UNDER, vu[15:0]);
        write_cfg(ledfp_pkg::CFG_VIN_OVER, vo[15:0]);
        write_cfg(ledfp_pkg::CFG_VIN_UNDER_RECOVER, vur[15:0]);
        write_cfg(ledfp_pkg::CFG_VIN_OVER_RECOVER, vor[15:0]);
    endtask

    task apply_setting(input int phase);
        int ts, tw, tc, vu, vo, vur, vor;
        case (phase)
            2: write_thresholds(16'h0FFF, 16'h1000, 16'h1000, 0, 65535, 0, 65535);
            3: write_thresholds(16'h1000, 16'h0FFF, 16'h0FFF, 65535, 0, 65535, 0);
            4, 5: begin
                write_thresholds($urandom_range(65535), $urandom_range(65535),
                                 $urandom_range(65535), $urandom_range(65535),
                                 $urandom_range(65535), $urandom_range(65535),
                                 $urandom_range(65535));
                // A request to an unused index must leave every threshold alone.
                write_cfg(CFG_UNUSED_INDEX, 16'($urandom_range(65535)));
            end
            default: begin
                ts  = $urandom_range(2400, 1200);
                tw  = ts - int'($urandom_range(400, 50));
                tc  = tw - int'($urandom_range(200));
                vu  = $urandom_range(45000, 30000);
                vur = vu + int'($urandom_range(3000));
                vo  = vur + int'($urandom_range(15000, 2000));
                vor = vo - int'($urandom_range(3000));
                write_thresholds(ts, tw, tc, vu, vo, vur, vor);
            end
        endcase
    endtask

    initial begin
        ledfp_pkg::sample_t directed[$];
        repeat (12) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Band edges at the reset thresholds, then retry saturation per channel.
        directed.push_back(mk_sample(48000, 400, 0, 0));
        directed.push_back(mk_sample(48000, 1440, 0, 0));
        directed.push_back(mk_sample(48000, 1300, 0, 0));
        directed.push_back(mk_sample(48000, 1279, 0, 0));
        directed.push_back(mk_sample(39999, 400, 0, 0));
        directed.push_back(mk_sample(42000, 400, 0, 0));
        directed.push_back(mk_sample(42001, 400, 0, 0));
        directed.push_back(mk_sample(56001, 400, 0, 0));
        directed.push_back(mk_sample(54000, 400, 0, 0));
        directed.push_back(mk_sample(53999, 400, 0, 0));
        directed.push_back(mk_sample(0, -4096, 0, 0));
        directed.push_back(mk_sample(65535, 4095, 0, 0));
        directed.push_back(mk_sample(48000, 1759, 0, 0));
        repeat (4) directed.push_back(mk_sample(48000, 400, 1, 0));
        repeat (4) directed.push_back(mk_sample(48000, 400, 0, 1));
        directed.push_back(mk_sample(48000, 400, 1, 1));
        directed.push_back(mk_sample(40000, 1760, 1, 1));
        directed.push_back(mk_sample(56000, 400, 0, 0));
        foreach (directed[i]) send_sample(directed[i]);
        drain();

        for (int phase = 1; phase <= 6; phase++) begin
            apply_setting(phase);
            no_idle = (phase == 3);
            repeat (PHASE_ITEMS) send_sample(random_sample());
            drain();
        end
        no_idle = 1'b0;

        repeat (10) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("led_driver_fault_protection_unit regression: pass");
        end else begin
            $display("led_driver_fault_protection_unit regression: fail");
        end
        $finish;
    end

endmodule

FILE: led_driver_fault_protection_unit.f
rtl/ledfp_pkg.sv
rtl/led_driver_fault_protection_unit.sv
sim/led_driver_fault_protection_unit_tb.sv
